// File: rtl/assert_macros.svh
// assertion helpers, sampled on the rising clock edge, off while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge
`define AST_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define AST_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AST_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/gh_pkg.sv
// ----------------------------------------------------------------------------
// gh_pkg
// Shared types, constants and the base32 alphabet of the geohash encoder.
// ----------------------------------------------------------------------------
package gh_pkg;

   localparam int GROUP_BITS = 5;
   localparam int HASH_W     = 60;
   localparam int CODE_W     = 7;

   // coordinate limits in units of 1e-7 degree
   localparam logic signed [30:0] LAT_MIN = -31'sd900000000;
   localparam logic signed [30:0] LAT_MAX = 31'sd900000000;
   localparam logic signed [31:0] LON_MIN = -32'sd1800000000;
   localparam logic signed [31:0] LON_MAX = 32'sd1800000000;

   // offset that moves a coordinate to zero-based, and the full interval width
   localparam logic [30:0] LAT_OFFSET = 31'd900000000;
   localparam logic [31:0] LON_OFFSET = 32'd1800000000;
   localparam logic [30:0] LAT_RANGE  = 31'd1800000000;
   localparam logic [31:0] LON_RANGE  = 32'd3600000000;

   // controls from the sequencer to the character emitter
   typedef struct packed {
      logic clear;       // start of a new item
      logic shift;       // one bisection step
      logic hash_en;     // this step produces a hash bit
      logic hbit;        // the hash bit of this step
      logic put_char;    // load one character result
      logic put_single;  // load the lone result of an empty or bad item
      logic single_ok;   // ok flag for the lone result
      logic last;        // final character of the item
   } emit_ctl_type;

   function automatic logic [CODE_W-1:0] b32_char(input logic [GROUP_BITS-1:0] idx);
      logic [CODE_W-1:0] c;
      case (idx)
         5'd0:    c = 7'h30;
         5'd1:    c = 7'h31;
         5'd2:    c = 7'h32;
         5'd3:    c = 7'h33;
         5'd4:    c = 7'h34;
         5'd5:    c = 7'h35;
         5'd6:    c = 7'h36;
         5'd7:    c = 7'h37;
         5'd8:    c = 7'h38;
         5'd9:    c = 7'h39;
         5'd10:   c = 7'h62;  // b
         5'd11:   c = 7'h63;
         5'd12:   c = 7'h64;
         5'd13:   c = 7'h65;
         5'd14:   c = 7'h66;
         5'd15:   c = 7'h67;
         5'd16:   c = 7'h68;
         5'd17:   c = 7'h6a;  // j, no i
         5'd18:   c = 7'h6b;
         5'd19:   c = 7'h6d;  // m, no l
         5'd20:   c = 7'h6e;
         5'd21:   c = 7'h70;  // p, no o
         5'd22:   c = 7'h71;
         5'd23:   c = 7'h72;
         5'd24:   c = 7'h73;
         5'd25:   c = 7'h74;
         5'd26:   c = 7'h75;
         5'd27:   c = 7'h76;
         5'd28:   c = 7'h77;
         5'd29:   c = 7'h78;
         5'd30:   c = 7'h79;
         5'd31:   c = 7'h7a;  // z
         default: c = 7'h30;
      endcase
      return c;
   endfunction

endpackage

// File: rtl/gh_bisect.sv
// ----------------------------------------------------------------------------
// gh_bisect
// One axis of the bisection: a restoring division of the zero-based
// coordinate by the interval width, one quotient bit per step.
// ----------------------------------------------------------------------------
module gh_bisect #(
   parameter int            RW       = 32,
   parameter logic [RW-1:0] SPAN_VAL = '1
) (
   input  logic          clock,
   input  logic          load,
   input  logic [RW-1:0] load_val,
   input  logic          step,
   output logic          hi_bit
);

   // remainder stays at or below the interval width
   logic [RW-1:0] rem_ff, rem_in;
   logic [RW:0]   dbl;
   logic [RW:0]   diff;

   always_comb begin
      dbl    = {rem_ff, 1'b0};
      diff   = dbl - {1'b0, SPAN_VAL};
      hi_bit = (dbl >= {1'b0, SPAN_VAL});
      rem_in = rem_ff;
      if (load) begin
         rem_in = load_val;
      end else if (step) begin
         rem_in = hi_bit ? diff[RW-1:0] : dbl[RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

endmodule

// File: rtl/gh_emit.sv
// ----------------------------------------------------------------------------
// gh_emit
// Collects hash bits, left-aligns them in a group shift register and sends
// one base32 character per character result through the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gh_emit
   import gh_pkg::*;
#(
   parameter int GW = 60
) (
   input  logic                clock,
   input  logic                reset,
   input  emit_ctl_type        ctl,
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [HASH_W-1:0]   rsp_hash_value,
   output logic [CODE_W-1:0]   rsp_char_code,
   output logic                rsp_char_valid,
   output logic                rsp_last,
   output logic                rsp_ok
);

   logic [GW-1:0]     hash_ff, hash_in;
   logic [GW-1:0]     group_ff, group_in;
   logic              valid_ff, valid_in;
   logic [HASH_W-1:0] hash_out_ff, hash_out_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic              cv_ff, cv_in;
   logic              last_ff, last_in;
   logic              ok_ff, ok_in;
   logic              put;

   assign free = !valid_ff || !rsp_stall;
   assign put  = ctl.put_char || ctl.put_single;

   always_comb begin
      hash_in  = hash_ff;
      group_in = group_ff;
      if (ctl.clear) begin
         hash_in  = '0;
         group_in = '0;
      end else if (ctl.shift) begin
         // pad steps shift zeros so the hash ends up left-aligned
         group_in = (group_ff << 1) | GW'(ctl.hbit & ctl.hash_en);
         if (ctl.hash_en) begin
            hash_in = (hash_ff << 1) | GW'(ctl.hbit);
         end
      end else if (ctl.put_char) begin
         group_in = group_ff << GROUP_BITS;
      end
   end

   always_comb begin
      hash_out_in = hash_out_ff;
      code_in     = code_ff;
      cv_in       = cv_ff;
      last_in     = last_ff;
      ok_in       = ok_ff;
      if (ctl.put_char) begin
         hash_out_in = HASH_W'(hash_ff);
         code_in     = b32_char(group_ff[GW-1 -: GROUP_BITS]);
         cv_in       = 1'b1;
         last_in     = ctl.last;
         ok_in       = 1'b1;
      end else if (ctl.put_single) begin
         hash_out_in = '0;
         code_in     = '0;
         cv_in       = 1'b0;
         last_in     = 1'b1;
         ok_in       = ctl.single_ok;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (put) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff     <= hash_in;
      group_ff    <= group_in;
      hash_out_ff <= hash_out_in;
      code_ff     <= code_in;
      cv_ff       <= cv_in;
      last_ff     <= last_in;
      ok_ff       <= ok_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_hash_value = hash_out_ff;
   assign rsp_char_code  = code_ff;
   assign rsp_char_valid = cv_ff;
   assign rsp_last       = last_ff;
   assign rsp_ok         = ok_ff;

   `AST_IMPLY(a_put_needs_slot, put, !valid_ff || !rsp_stall, "result loaded over a waiting one")
   `AST_NEXT(a_char_is_ok, ctl.put_char, rsp_valid && rsp_ok && rsp_char_valid, "char result lost flags")

endmodule

// File: rtl/geohash_encoder.sv
// ----------------------------------------------------------------------------
// geohash_encoder
// Encodes a position into a geohash, one bisection bit per cycle.
//
// Input channel req_*: latitude and longitude in 1e-7 degree and a length
// in characters. A transfer happens when req_valid is high and req_stall
// is low; req_stall stays high until every result of the item has moved
// into the output register, so one item is worked on at a time.
// Result channel rsp_*: one transfer per character, rsp_last on the final
// one. Every character result repeats the whole right-aligned hash.
// A zero length gives one result without a character; a bad length or
// coordinate gives one result with rsp_ok low.
// Sequence: a valid item runs bisection steps for every bit of the group
// width, padding past the hash length (lon and lat units take turns, one
// restoring-division step each), then loads one character whenever the
// output register is free; an empty or bad item goes through S_SINGLE.
// While rsp_stall is high the output register holds its result and the
// emitter waits. Reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module geohash_encoder
   import gh_pkg::*;
#(
   parameter int MAX_CHARS = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [30:0]  req_latitude,
   input  logic signed [31:0]  req_longitude,
   input  logic [3:0]          req_char_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [HASH_W-1:0]   rsp_hash_value,
   output logic [CODE_W-1:0]   rsp_char_code,
   output logic                rsp_char_valid,
   output logic                rsp_last,
   output logic                rsp_ok
);

   localparam int GW = GROUP_BITS * MAX_CHARS;
   localparam int SW = $clog2(GW);
   localparam int NW = $clog2(GW + 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_CALC   = 4'b0010,
      S_EMIT   = 4'b0100,
      S_SINGLE = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;
   logic [NW-1:0] nbits_ff, nbits_in;
   logic [3:0]   count_ff, count_in;
   logic [3:0]   idx_ff, idx_in;
   logic         turn_ff, turn_in;      // high on a longitude step
   logic         sok_ff, sok_in;

   logic         accept;
   logic         in_ok;
   logic         run;
   logic [5:0]   count5;
   logic [30:0]  lat_zero;
   logic [31:0]  lon_zero;
   logic         lat_bit, lon_bit;
   logic         hash_en;
   logic         free;
   logic         last_char;
   emit_ctl_type ctl;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   assign in_ok = (32'(req_char_count) <= MAX_CHARS) &&
                  (req_latitude >= LAT_MIN) && (req_latitude <= LAT_MAX) &&
                  (req_longitude >= LON_MIN) && (req_longitude <= LON_MAX);
   assign run   = in_ok && (req_char_count != 4'd0);

   assign count5   = ({2'b00, req_char_count} << 2) + {2'b00, req_char_count};
   assign lat_zero = req_latitude + LAT_OFFSET;
   assign lon_zero = req_longitude + LON_OFFSET;

   assign hash_en   = (state_ff == S_CALC) && (NW'(step_ff) < nbits_ff);
   assign last_char = (idx_ff == count_ff - 4'd1);

   gh_bisect #(
      .RW       (32),
      .SPAN_VAL (LON_RANGE)
   ) u_lon (
      .clock    (clock),
      .load     (accept && run),
      .load_val (lon_zero),
      .step     (hash_en && turn_ff),
      .hi_bit   (lon_bit)
   );

   gh_bisect #(
      .RW       (31),
      .SPAN_VAL (LAT_RANGE)
   ) u_lat (
      .clock    (clock),
      .load     (accept && run),
      .load_val (lat_zero),
      .step     (hash_en && !turn_ff),
      .hi_bit   (lat_bit)
   );

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      nbits_in = nbits_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      turn_in  = turn_ff;
      sok_in   = sok_ff;

      ctl            = '0;
      ctl.hash_en    = hash_en;
      ctl.hbit       = turn_ff ? lon_bit : lat_bit;
      ctl.single_ok  = sok_ff;
      ctl.last       = last_char;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ctl.clear = 1'b1;
               count_in  = req_char_count;
               nbits_in  = NW'(count5);
               step_in   = '0;
               idx_in    = '0;
               turn_in   = 1'b1;
               sok_in    = in_ok;
               state_in  = run ? S_CALC : S_SINGLE;
            end
         end
         S_CALC: begin
            // every step shifts; steps past the hash length only pad
            ctl.shift = 1'b1;
            turn_in   = !turn_ff;
            step_in   = step_ff + SW'(1);
            if (step_ff == SW'(GW - 1)) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (free) begin
               ctl.put_char = 1'b1;
               idx_in       = idx_ff + 4'd1;
               if (last_char) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SINGLE: begin
            if (free) begin
               ctl.put_single = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         idx_ff   <= '0;
         turn_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         idx_ff   <= idx_in;
         turn_ff  <= turn_in;
      end
   end

   always_ff @(posedge clock) begin
      nbits_ff <= nbits_in;
      count_ff <= count_in;
      sok_ff   <= sok_in;
   end

   gh_emit #(
      .GW (GW)
   ) u_emit (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .free           (free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value),
      .rsp_char_code  (rsp_char_code),
      .rsp_char_valid (rsp_char_valid),
      .rsp_last       (rsp_last),
      .rsp_ok         (rsp_ok)
   );

   `AST_NEXT(a_accept_busy, accept, state_ff != S_IDLE, "transfer did not start work")
   `AST_IMPLY(a_emit_index, state_ff == S_EMIT, idx_ff < count_ff, "char index past length")
   `AST_IMPLY(a_step_range, state_ff == S_CALC, NW'(step_ff) < NW'(GW), "step past hash width")

endmodule
